// ----- hw/rtl/wrg_pkg.sv -----
// Shared types, constants and arithmetic helpers of the water ripple grid block.
package wrg_pkg;

  localparam int GRID_W_DEF = 64;
  localparam int GRID_H_DEF = 64;

  // Command codes of the kind field.
  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_DRY    = 3'd1;
  localparam logic [2:0] KIND_SPLASH = 3'd2;
  localparam logic [2:0] KIND_RIPPLE = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // 1/sqrt2 in Q0.16 and 0.003 in Q0.32.
  localparam logic signed [16:0] DIAG_K = 17'sd46341;
  localparam logic signed [24:0] VEL_K  = 25'sd12884902;

  localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic signed [31:0] splash_height;
    logic               dry_flag;
  } wrg_in_t;

  typedef struct packed {
    logic signed [31:0] height_out;
    logic               status;
  } wrg_out_t;

  // Clamp a widened sum back into the signed 32-bit range.
  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/wrg_channels.sv -----
// Handshake channels of the water ripple grid block: input, result and configuration.
interface wrg_in_if;
  logic             valid;
  logic             ready;
  wrg_pkg::wrg_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wrg_out_if;
  logic              valid;
  logic              ready;
  wrg_pkg::wrg_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wrg_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/wrg_ram.sv -----
// Simple dual-port synchronous RAM with one write port and one registered read port.
module wrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/water_ripple_grid_step_unit.sv -----
// Top level of the water ripple grid: command sequencer around the cell memories.
//
// The block keeps a GRID_W x GRID_H field of water cells (height, velocity and
// force in Q16.16, plus a dry flag) in four synchronous memories and takes one
// command word at a time: clear motion, write a dry flag, place a 2x2 splash,
// run one ripple step, or read a height. Each command returns exactly one result
// word. After reset the block sweeps all GRID_W*GRID_H cells to zero, one per
// cycle, before it takes its first command; configuration writes are taken at any
// time. Clear motion sweeps every cell in turn and a splash writes its four cells
// one by one. A ripple step is a read-modify-write walk through the force memory:
// each wet interior cell is read, then each of its six neighbors is read,
// multiplied and written in turn, then its own force is written; a dry interior
// cell is only read. The integrate walk that follows reads, updates and writes
// each wet cell of the whole grid and only reads each dry cell. Every spring
// exchange goes through the single force memory. A finished result waits in an
// output register, so the next command word is accepted while the previous
// result has not yet been taken.
module water_ripple_grid_step_unit #(
  parameter int GRID_W = wrg_pkg::GRID_W_DEF,
  parameter int GRID_H = wrg_pkg::GRID_H_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  wrg_in_if.sink    in_i,
  wrg_cfg_if.sink   cfg_i,
  wrg_out_if.source out_o
);

  import wrg_pkg::*;

  localparam int NCELLS = GRID_W * GRID_H;
  localparam int AW     = $clog2(NCELLS);
  localparam int XW     = $clog2(GRID_W);
  localparam int YW     = $clog2(GRID_H);
  // Reciprocal of the cell count, rounded up, so that (|h| * RECIP) >> DIV_SH
  // equals floor(|h| / NCELLS) for every 32-bit magnitude.
  localparam int DIV_SH = 32 + $clog2(NCELLS);
  localparam logic [65:0] RECIP_FULL = ((66'(1) << DIV_SH) + 66'(NCELLS) - 66'(1))
                                       / 66'(NCELLS);
  localparam logic [33:0] RECIP = RECIP_FULL[33:0];

  localparam logic [AW-1:0] W_A     = AW'(GRID_W);
  localparam logic [AW-1:0] LAST_A  = AW'(NCELLS - 1);
  localparam logic [XW-1:0] X_LAST  = XW'(GRID_W - 1);
  localparam logic [XW-1:0] X_INL   = XW'(GRID_W - 2);
  localparam logic [YW-1:0] Y_INL   = YW'(GRID_H - 2);

  // Neighbor order of the force exchange; the last three are diagonal.
  localparam logic [2:0] NB_DOWN = 3'd0;
  localparam logic [2:0] NB_UP   = 3'd1;
  localparam logic [2:0] NB_RT   = 3'd2;
  localparam logic [2:0] NB_UR   = 3'd3;
  localparam logic [2:0] NB_DL   = 3'd4;
  localparam logic [2:0] NB_UL   = 3'd5;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_SPLASH, ST_RDAT,
    ST_F_CELL, ST_F_CDAT, ST_F_NRD, ST_F_NMUL, ST_F_NWR, ST_F_CWR,
    ST_I_RD, ST_I_MUL, ST_I_VEL, ST_I_DIV, ST_I_WR, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [2:0] nbr_q, nbr_d;
  logic [1:0] sub_q, sub_d;
  logic [AW-1:0] item_addr_q, item_addr_d;
  logic signed [31:0] spl_q, spl_d;
  logic signed [31:0] hc_q, hc_d;
  logic signed [31:0] fc_q, fc_d;
  logic signed [31:0] nf_q, nf_d;
  logic signed [32:0] d_q, d_d;
  logic signed [49:0] prod_q, prod_d;
  logic signed [31:0] h_q, h_d;
  logic signed [31:0] v_q, v_d;
  logic signed [56:0] pv_q, pv_d;
  logic signed [31:0] h1_q, h1_d;
  logic signed [31:0] vn_q, vn_d;
  logic [65:0] pq_q, pq_d;
  wrg_out_t res_q, res_d;
  wrg_out_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic en_q;

  // Memory ports.
  logic re;
  logic [AW-1:0] raddr, waddr;
  logic we_h, we_v, we_f, we_dry;
  logic [31:0] wdata_h, wdata_v, wdata_f;
  logic wdata_dry;
  logic [31:0] h_rd_raw, v_rd_raw, f_rd_raw;
  logic signed [31:0] h_rd, v_rd, f_rd;
  logic dry_rd;

  logic in_acc;
  logic in_inside, splash_ok;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] nbr_addr;
  logic [2:0] taper;

  wrg_ram #(.WIDTH(32), .DEPTH(NCELLS)) u_height (
    .clk_i, .we_i(we_h), .waddr_i(waddr), .wdata_i(wdata_h),
    .re_i(re), .raddr_i(raddr), .rdata_o(h_rd_raw)
  );
  wrg_ram #(.WIDTH(32), .DEPTH(NCELLS)) u_velocity (
    .clk_i, .we_i(we_v), .waddr_i(waddr), .wdata_i(wdata_v),
    .re_i(re), .raddr_i(raddr), .rdata_o(v_rd_raw)
  );
  wrg_ram #(.WIDTH(32), .DEPTH(NCELLS)) u_force (
    .clk_i, .we_i(we_f), .waddr_i(waddr), .wdata_i(wdata_f),
    .re_i(re), .raddr_i(raddr), .rdata_o(f_rd_raw)
  );
  wrg_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_dry (
    .clk_i, .we_i(we_dry), .waddr_i(waddr), .wdata_i(wdata_dry),
    .re_i(re), .raddr_i(raddr), .rdata_o(dry_rd)
  );

  assign h_rd = $signed(h_rd_raw);
  assign v_rd = $signed(v_rd_raw);
  assign f_rd = $signed(f_rd_raw);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Addressing of the incoming command word.
  assign in_inside = (32'(in_i.data.cell_x) < GRID_W) && (32'(in_i.data.cell_y) < GRID_H);
  assign in_addr   = AW'(32'(in_i.data.cell_y) * GRID_W + 32'(in_i.data.cell_x));
  assign splash_ok = en_q && (in_i.data.cell_x != 6'd0) && (in_i.data.cell_y != 6'd0) &&
                     (32'(in_i.data.cell_x) < GRID_W - 2) &&
                     (32'(in_i.data.cell_y) < GRID_H - 2);

  always_comb begin
    case (nbr_q)
      NB_DOWN: nbr_addr = addr_q - W_A;
      NB_UP:   nbr_addr = addr_q + W_A;
      NB_RT:   nbr_addr = addr_q + AW'(1);
      NB_UR:   nbr_addr = addr_q + W_A + AW'(1);
      NB_DL:   nbr_addr = addr_q - W_A - AW'(1);
      NB_UL:   nbr_addr = addr_q + W_A - AW'(1);
      default: nbr_addr = addr_q;
    endcase
  end

  // Edge taper in quarters: ramps over the first four and the last three rows and columns.
  always_comb begin
    if (32'(x_q) < 4) begin
      taper = 3'(x_q);
    end else if (32'(y_q) < 4) begin
      taper = 3'(y_q);
    end else if (32'(x_q) > GRID_W - 4) begin
      taper = 3'(32'(x_q) - (GRID_W - 4));
    end else if (32'(y_q) > GRID_H - 4) begin
      taper = 3'(32'(y_q) - (GRID_H - 4));
    end else begin
      taper = 3'd4;
    end
  end

  always_comb begin
    logic adv_f, adv_i;
    logic signed [33:0] f_w;
    logic signed [31:0] fc_new, fn_new;
    logic signed [24:0] dv;
    logic signed [31:0] vn;
    logic [31:0] mag, q;
    logic signed [32:0] h1s, q33, h2;
    logic signed [35:0] h3, h4;

    state_d = state_q;
    addr_d = addr_q;
    x_d = x_q;
    y_d = y_q;
    nbr_d = nbr_q;
    sub_d = sub_q;
    item_addr_d = item_addr_q;
    spl_d = spl_q;
    hc_d = hc_q;
    fc_d = fc_q;
    nf_d = nf_q;
    d_d = d_q;
    prod_d = prod_q;
    h_d = h_q;
    v_d = v_q;
    pv_d = pv_q;
    h1_d = h1_q;
    vn_d = vn_q;
    pq_d = pq_q;
    res_d = res_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    re = 1'b0;
    raddr = addr_q;
    waddr = addr_q;
    we_h = 1'b0;
    we_v = 1'b0;
    we_f = 1'b0;
    we_dry = 1'b0;
    wdata_h = '0;
    wdata_v = '0;
    wdata_f = '0;
    wdata_dry = 1'b0;
    adv_f = 1'b0;
    adv_i = 1'b0;

    // Force exchange with the current neighbor.
    if (nbr_q >= NB_UR) begin
      f_w = 34'((prod_q + 50'sd32768) >>> 16);
    end else begin
      f_w = 34'(d_q);
    end
    fc_new = sat35(35'(fc_q) - 35'(f_w));
    fn_new = sat35(35'(nf_q) + 35'(f_w));

    // Integration: velocity, height, damping and taper.
    dv  = 25'((pv_q + 57'sd2147483648) >>> 32);
    vn  = sat35(35'(v_q) + 35'(dv));
    mag = h1_q[31] ? 32'(-33'(h1_q)) : 32'(h1_q);
    q   = 32'(pq_q >> DIV_SH);
    h1s = 33'(h1_q);
    q33 = $signed({1'b0, q});
    h2  = h1_q[31] ? (h1s + q33) : (h1s - q33);
    h3  = 36'(h2) * 36'($signed({1'b0, taper}));
    h4  = h3[35] ? ((h3 + 36'sd3) >>> 2) : (h3 >>> 2);

    unique case (state_q)
      ST_INIT: begin
        we_h = 1'b1;
        we_v = 1'b1;
        we_f = 1'b1;
        we_dry = 1'b1;
        if (addr_q == LAST_A) begin
          addr_d = '0;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          item_addr_d = in_addr;
          spl_d = in_i.data.splash_height;
          state_d = ST_DONE;
          case (in_i.data.kind)
            KIND_CLEAR: begin
              addr_d = '0;
              state_d = ST_CLR;
            end
            KIND_DRY: begin
              waddr = in_addr;
              we_dry = in_inside;
              wdata_dry = in_i.data.dry_flag;
            end
            KIND_SPLASH: begin
              if (splash_ok) begin
                sub_d = '0;
                state_d = ST_SPLASH;
              end else begin
                res_d.status = 1'b1;
              end
            end
            KIND_RIPPLE: begin
              if (en_q) begin
                addr_d = W_A + AW'(1);
                x_d = XW'(1);
                y_d = YW'(1);
                state_d = ST_F_CELL;
              end
            end
            KIND_READ: begin
              if (in_inside) begin
                re = 1'b1;
                raddr = in_addr;
                state_d = ST_RDAT;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_CLR: begin
        we_h = 1'b1;
        we_v = 1'b1;
        we_f = 1'b1;
        if (addr_q == LAST_A) begin
          state_d = ST_DONE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_SPLASH: begin
        waddr = item_addr_q + (sub_q[0] ? AW'(1) : AW'(0)) + (sub_q[1] ? W_A : AW'(0));
        we_h = 1'b1;
        wdata_h = spl_q;
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd3) begin
          state_d = ST_DONE;
        end
      end
      ST_RDAT: begin
        res_d.height_out = h_rd;
        state_d = ST_DONE;
      end
      ST_F_CELL: begin
        re = 1'b1;
        state_d = ST_F_CDAT;
      end
      ST_F_CDAT: begin
        if (dry_rd) begin
          adv_f = 1'b1;
        end else begin
          hc_d = h_rd;
          fc_d = f_rd;
          nbr_d = NB_DOWN;
          state_d = ST_F_NRD;
        end
      end
      ST_F_NRD: begin
        re = 1'b1;
        raddr = nbr_addr;
        state_d = ST_F_NMUL;
      end
      ST_F_NMUL: begin
        d_d = 33'(hc_q) - 33'(h_rd);
        prod_d = 50'(33'(hc_q) - 33'(h_rd)) * 50'(DIAG_K);
        nf_d = f_rd;
        state_d = ST_F_NWR;
      end
      ST_F_NWR: begin
        waddr = nbr_addr;
        we_f = 1'b1;
        wdata_f = fn_new;
        fc_d = fc_new;
        if (nbr_q == NB_UL) begin
          state_d = ST_F_CWR;
        end else begin
          nbr_d = nbr_q + 3'd1;
          state_d = ST_F_NRD;
        end
      end
      ST_F_CWR: begin
        we_f = 1'b1;
        wdata_f = fc_q;
        adv_f = 1'b1;
      end
      ST_I_RD: begin
        re = 1'b1;
        state_d = ST_I_MUL;
      end
      ST_I_MUL: begin
        if (dry_rd) begin
          adv_i = 1'b1;
        end else begin
          h_d = h_rd;
          v_d = v_rd;
          pv_d = 57'(f_rd) * 57'(VEL_K);
          state_d = ST_I_VEL;
        end
      end
      ST_I_VEL: begin
        vn_d = vn;
        h1_d = sat35(35'(h_q) + 35'(vn));
        state_d = ST_I_DIV;
      end
      ST_I_DIV: begin
        pq_d = 66'(mag) * 66'(RECIP);
        state_d = ST_I_WR;
      end
      ST_I_WR: begin
        we_h = 1'b1;
        we_v = 1'b1;
        we_f = 1'b1;
        wdata_h = h4[31:0];
        wdata_v = vn_q;
        adv_i = 1'b1;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_d = res_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Row-major walk over the interior cells, then over the whole grid.
    if (adv_f) begin
      if (x_q == X_INL && y_q == Y_INL) begin
        addr_d = '0;
        x_d = '0;
        y_d = '0;
        state_d = ST_I_RD;
      end else if (x_q == X_INL) begin
        x_d = XW'(1);
        y_d = y_q + YW'(1);
        addr_d = addr_q + AW'(3);
        state_d = ST_F_CELL;
      end else begin
        x_d = x_q + XW'(1);
        addr_d = addr_q + AW'(1);
        state_d = ST_F_CELL;
      end
    end
    if (adv_i) begin
      if (addr_q == LAST_A) begin
        state_d = ST_DONE;
      end else begin
        addr_d = addr_q + AW'(1);
        state_d = ST_I_RD;
        if (x_q == X_LAST) begin
          x_d = '0;
          y_d = y_q + YW'(1);
        end else begin
          x_d = x_q + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      addr_q <= '0;
      x_q <= '0;
      y_q <= '0;
      nbr_q <= '0;
      sub_q <= '0;
      item_addr_q <= '0;
      spl_q <= '0;
      hc_q <= '0;
      fc_q <= '0;
      nf_q <= '0;
      d_q <= '0;
      prod_q <= '0;
      h_q <= '0;
      v_q <= '0;
      pv_q <= '0;
      h1_q <= '0;
      vn_q <= '0;
      pq_q <= '0;
      res_q <= '0;
      out_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q <= addr_d;
      x_q <= x_d;
      y_q <= y_d;
      nbr_q <= nbr_d;
      sub_q <= sub_d;
      item_addr_q <= item_addr_d;
      spl_q <= spl_d;
      hc_q <= hc_d;
      fc_q <= fc_d;
      nf_q <= nf_d;
      d_q <= d_d;
      prod_q <= prod_d;
      h_q <= h_d;
      v_q <= v_d;
      pv_q <= pv_d;
      h1_q <= h1_d;
      vn_q <= vn_d;
      pq_q <= pq_d;
      res_q <= res_d;
      out_q <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Movement enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      en_q <= cfg_i.data;
    end
  end

  // An accepted command always leaves the idle state.
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("command accepted without leaving idle");

  // A result word appears only when a command completes.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result word raised outside completion");

  // An ignored splash never reports a height.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status) |-> out_q.height_out == '0)
    else $error("status set with nonzero height");

  // No command is taken while the sequencer is busy.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready)
    else $error("ready raised while busy");

endmodule

// ----- verif/tb_water_ripple_grid_step_unit.sv -----
// Self-checking testbench of the water ripple grid: a command stream checked against a cell model.
`timescale 1ns / 1ps

import wrg_pkg::*;

class water_grid_tracker;
  localparam int W = GRID_W_DEF;
  localparam int H = GRID_H_DEF;
  localparam int N = W * H;

  int        cell_h[N];
  int        cell_v[N];
  int        cell_f[N];
  bit        cell_dry[N];
  bit        move_en;
  wrg_out_t  pending_results[$];
  int        errors;

  function new();
    clear_motion();
    foreach (cell_dry[i]) cell_dry[i] = 1'b0;
    move_en = 1'b1;
    errors  = 0;
  endfunction

  function int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function void clear_motion();
    foreach (cell_h[i]) begin
      cell_h[i] = 0;
      cell_v[i] = 0;
      cell_f[i] = 0;
    end
  endfunction

  function longint edge_taper(int x, int y);
    if (x < 4) return x;
    if (y < 4) return y;
    if (x > W - 4) return x - (W - 4);
    if (y > H - 4) return y - (H - 4);
    return 4;
  endfunction

  // Spring pass over wet interior cells, then integration of every wet cell.
  function void ripple_step();
    int     offs[6];
    int     c;
    int     nb;
    longint d;
    longint vel;
    longint hh;
    offs = '{-W, W, 1, W + 1, -W - 1, W - 1};
    for (int y = 1; y < H - 1; y++) begin
      for (int x = 1; x < W - 1; x++) begin
        c = y * W + x;
        if (!cell_dry[c]) begin
          for (int k = 0; k < 6; k++) begin
            nb = c + offs[k];
            d  = longint'(cell_h[c]) - longint'(cell_h[nb]);
            // Diagonal springs: times 1/sqrt2 in Q0.16, rounded half up.
            if (k >= 3) d = (d * 46341 + 32768) >>> 16;
            cell_f[c]  = clamp32(longint'(cell_f[c]) - d);
            cell_f[nb] = clamp32(longint'(cell_f[nb]) + d);
          end
        end
      end
    end
    for (int y = 0; y < H; y++) begin
      for (int x = 0; x < W; x++) begin
        c = y * W + x;
        if (!cell_dry[c]) begin
          vel = (longint'(cell_f[c]) * 12884902 + (64'sd1 <<< 31)) >>> 32;
          cell_v[c] = clamp32(longint'(cell_v[c]) + vel);
          hh = clamp32(longint'(cell_h[c]) + longint'(cell_v[c]));
          hh = hh - hh / N;
          hh = (hh * edge_taper(x, y)) / 4;
          cell_h[c] = int'(hh);
          cell_f[c] = 0;
        end
      end
    end
  endfunction

  function void set_enable(bit v);
    move_en = v;
  endfunction

  // Called for every command word the block accepts.
  function void note_command(wrg_in_t w);
    wrg_out_t r;
    int       c;
    r = '0;
    c = int'(w.cell_y) * W + int'(w.cell_x);
    case (w.kind)
      KIND_CLEAR: clear_motion();
      KIND_DRY: cell_dry[c] = w.dry_flag;
      KIND_SPLASH: begin
        if (move_en && w.cell_x > 0 && w.cell_y > 0 && w.cell_x < W - 2 && w.cell_y < H - 2) begin
          cell_h[c]         = w.splash_height;
          cell_h[c + 1]     = w.splash_height;
          cell_h[c + W]     = w.splash_height;
          cell_h[c + W + 1] = w.splash_height;
        end else begin
          r.status = 1'b1;
        end
      end
      KIND_RIPPLE: if (move_en) ripple_step();
      KIND_READ: r.height_out = cell_h[c];
      default: ;
    endcase
    pending_results.push_back(r);
  endfunction

  function void check_result(wrg_out_t got);
    wrg_out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result word, actual height %h status %b",
               $realtime, got.height_out, got.status);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.height_out !== want.height_out) begin
      $display("%0t: height mismatch, expected %h actual %h",
               $realtime, want.height_out, got.height_out);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status mismatch, expected %b actual %b",
               $realtime, want.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb_water_ripple_grid_step_unit;
  localparam int W = GRID_W_DEF;
  localparam int H = GRID_H_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wrg_in_if  in_if();
  wrg_cfg_if cfg_if();
  wrg_out_if out_if();

  water_ripple_grid_step_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  always #6 clk_i = ~clk_i;

  water_grid_tracker grid = new();

  // Idle percentages of the two sides, changed per phase.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int ripples_left;
  int last_x;
  int last_y;

  // Full-step ripples walk the whole grid, so the run budgets them.
  initial begin
    #50_000_000;
    $display("tb_water_ripple_grid_step_unit: FAIL");
    $finish;
  end

  // Result side: checks every word taken and drives ready, including the long hold-off.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) grid.check_result(out_if.data);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Valid stays high after an accepted word until the next word or an explicit stop.
  task automatic send_command(input wrg_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    grid.note_command(w);
  endtask

  task automatic send_fields(input logic [2:0] k, input int x, input int y,
                             input int hgt, input int dry);
    wrg_in_t w;
    w.kind          = k;
    w.cell_x        = x[5:0];
    w.cell_y        = y[5:0];
    w.splash_height = hgt;
    w.dry_flag      = dry[0];
    send_command(w);
  endtask

  // Waits until every expected word has come back, then writes movement_enable.
  task automatic write_enable(input bit v);
    in_if.valid <= 1'b0;
    while (grid.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    grid.set_enable(v);
    cfg_if.valid <= 1'b0;
  endtask

  // One random word; most are splash, step and read sequences around a splash.
  task automatic send_random();
    int   r;
    int   x;
    int   y;
    logic [2:0] k;
    r = $urandom_range(99);
    if (r < 4) begin
      if (ripples_left > 0 || !grid.move_en) begin
        if (grid.move_en) ripples_left--;
        send_fields(KIND_RIPPLE, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_fields(KIND_READ, last_x, last_y, $urandom, $urandom);
      end
    end else if (r < 7) begin
      send_fields(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 30) begin
      last_x = $urandom_range(1, W - 3);
      last_y = $urandom_range(1, H - 3);
      send_fields(KIND_SPLASH, last_x, last_y,
                  ($urandom_range(1) ? $urandom : $urandom_range(0, 32'h0004_0000)),
                  $urandom);
    end else if (r < 37) begin
      send_fields(KIND_SPLASH, $urandom_range(63), $urandom_range(63), $urandom, $urandom);
    end else if (r < 47) begin
      send_fields(KIND_DRY, $urandom_range(63), $urandom_range(63), $urandom,
                  int'($urandom_range(3) == 0));
    end else if (r < 85) begin
      x = last_x + $urandom_range(3) - 1;
      y = last_y + $urandom_range(3) - 1;
      send_fields(KIND_READ, x, y, $urandom, $urandom);
    end else if (r < 93) begin
      send_fields(KIND_READ, $urandom_range(63), $urandom_range(63), $urandom, $urandom);
    end else begin
      k = 3'($urandom_range(5, 7));
      send_fields(k, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    ripples_left   = 4;
    last_x         = 1;
    last_y         = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with movement enabled and no idling on either side.
    write_enable(1'b1);
    send_fields(KIND_READ, 0, 0, 0, 0);
    send_fields(KIND_READ, 63, 63, 0, 0);
    send_fields(KIND_DRY, 63, 0, 0, 1);
    send_fields(KIND_DRY, 5, 5, 0, 1);
    send_fields(KIND_SPLASH, 1, 1, 32'sh7FFF_FFFF, 0);
    send_fields(KIND_SPLASH, 61, 61, 32'sh8000_0000, 1);
    send_fields(KIND_SPLASH, 4, 4, 32'sh0001_8000, 0);
    send_fields(KIND_SPLASH, 0, 5, 32'h1234, 0);
    send_fields(KIND_SPLASH, 62, 5, 32'h1234, 0);
    send_fields(KIND_SPLASH, 5, 62, 32'h1234, 0);
    send_fields(3'd5, 63, 63, 32'hFFFF_FFFF, 1);
    send_fields(3'd6, 0, 0, 0, 0);
    send_fields(3'd7, 1, 1, 1, 1);
    send_fields(KIND_READ, 2, 2, 0, 0);
    send_fields(KIND_READ, 62, 62, 0, 0);
    // The extreme heights drive saturation in the step.
    send_fields(KIND_RIPPLE, 0, 0, 0, 0);
    ripples_left--;
    send_fields(KIND_READ, 5, 5, 0, 0);
    send_fields(KIND_READ, 1, 2, 0, 0);
    send_fields(KIND_READ, 60, 61, 0, 0);
    send_fields(KIND_DRY, 5, 5, 0, 0);
    send_fields(KIND_CLEAR, 0, 0, 0, 0);
    send_fields(KIND_READ, 2, 2, 0, 0);

    // Movement disabled: splashes report ignored and a step does nothing.
    write_enable(1'b0);
    send_fields(KIND_SPLASH, 10, 10, 32'h0002_0000, 0);
    send_fields(KIND_RIPPLE, 0, 0, 0, 0);
    send_fields(KIND_READ, 10, 10, 0, 0);
    write_enable(1'b1);

    // The receiver holds off while words keep coming, so the block stalls its input.
    hold_cycles = 300;
    for (int i = 0; i < 6; i++) send_fields(KIND_READ, i, i, 0, 0);

    // Random phases: sender idle, receiver stalling, both, and none.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 0) ? 86 : (ph == 2) ? 38 : 0;
      recv_stall_pct = (ph == 1) ? 86 : (ph == 2) ? 38 : 0;
      if (ph == 3) write_enable(1'b0);
      for (int i = 0; i < 20; i++) send_random();
      write_enable(1'b1);
    end
    for (int i = 0; i < 10; i++) send_random();

    in_if.valid <= 1'b0;
    while (grid.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (grid.errors == 0) begin
      $display("tb_water_ripple_grid_step_unit: PASS");
    end else begin
      $display("tb_water_ripple_grid_step_unit: FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/wrg_pkg.sv
hw/rtl/wrg_channels.sv
hw/rtl/wrg_ram.sv
hw/rtl/water_ripple_grid_step_unit.sv
verif/tb_water_ripple_grid_step_unit.sv
